// ===== sv/srce_pkg.sv =====
// shared types, codes and defaults of the register machine execute step
`timescale 1ns / 1ps

package srce_pkg;

  localparam int MEM_WORDS_DEF     = 32;
  localparam int REG_COUNT_DEF     = 4;
  localparam int PROGRAM_DEPTH_DEF = 256;
  localparam int WORD_BITS_DEF     = 32;

  // width of the magnitude compares on addresses and branch targets
  localparam int CMP_W    = 17;
  localparam int PC_OUT_W = 9;
  localparam int LEN_W    = 9;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 3;

  localparam logic [3:0] ACT_LOAD   = 4'd0;
  localparam logic [3:0] ACT_STORE  = 4'd1;
  localparam logic [3:0] ACT_MOVE   = 4'd2;
  localparam logic [3:0] ACT_ADD    = 4'd3;
  localparam logic [3:0] ACT_SUB    = 4'd4;
  localparam logic [3:0] ACT_AND    = 4'd5;
  localparam logic [3:0] ACT_OR     = 4'd6;
  localparam logic [3:0] ACT_BRANCH = 4'd7;
  localparam logic [3:0] ACT_BEZERO = 4'd8;
  localparam logic [3:0] ACT_HALT   = 4'd9;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_MEM    = 3'd1,
    ST_BAD_BRANCH = 3'd2,
    ST_BAD_OP     = 3'd3,
    ST_HALTED     = 3'd4
  } status_t;

  typedef struct packed {
    logic [3:0]          action;
    logic [1:0]          dest_reg;
    logic [1:0]          src_a_reg;
    logic [1:0]          src_b_reg;
    logic                load_from_memory;
    logic signed [31:0]  immediate;
    logic signed [15:0]  address;
  } instr_t;

  typedef struct packed {
    status_t status;
    logic    halt;
    logic    reg_we;
    logic    mem_we;
  } wb_ctl_t;

endpackage

// ===== sv/small_register_cpu_execute_step.sv =====
// top level of the register machine execute step
`timescale 1ns / 1ps

// Executes one decoded instruction per cycle, sustained while the output is not stalled
// and the memory is not being cleared, against a register file and a data memory held in
// synchronous RAMs. An accepted instruction reads its operands at the accept edge, then
// executes and writes back as it leaves the first stage and shows its result in the output
// register at that same edge; the registered reads of the RAMs set the depth of the pipeline,
// and a write at the edge of a following read is forwarded. After reset the data memory is
// cleared one word per cycle, with in_stall high throughout; configuration writes are taken throughout.

module small_register_cpu_execute_step #(
  parameter int MEM_WORDS     = srce_pkg::MEM_WORDS_DEF,
  parameter int REG_COUNT     = srce_pkg::REG_COUNT_DEF,
  parameter int PROGRAM_DEPTH = srce_pkg::PROGRAM_DEPTH_DEF,
  parameter int WORD_BITS     = srce_pkg::WORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [3:0]                  in_action,
  input  logic [1:0]                  in_dest_reg,
  input  logic [1:0]                  in_src_a_reg,
  input  logic [1:0]                  in_src_b_reg,
  input  logic                        in_load_from_memory,
  input  logic signed [31:0]          in_immediate,
  input  logic signed [15:0]          in_address,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [8:0]                  out_next_pc,
  output logic                        out_is_halted,
  output logic [2:0]                  out_status,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [srce_pkg::APB_AW-1:0] paddr,
  input  logic [srce_pkg::APB_DW-1:0] pwdata,
  output logic [srce_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);

  localparam int AW  = $clog2(MEM_WORDS);
  localparam int RIW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int RXW = (RIW > 2) ? RIW : 2;
  localparam int PCW = $clog2(PROGRAM_DEPTH + 1);
  localparam int CW  = srce_pkg::CMP_W;
  localparam int LW  = srce_pkg::LEN_W;
  localparam logic [CW-1:0] WORDS_C = CW'(MEM_WORDS);

  // configuration
  logic [LW-1:0] prog_len_r;
  logic          cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? '0 : srce_pkg::APB_DW'(prog_len_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prog_len_r <= '0;
    end else if (cfg_wr) begin
      prog_len_r <= pwdata[LW-1:0];
    end
  end

  // handshake and pipeline control
  logic             clr_busy;
  logic             in_acc;
  logic             s1_go;
  logic             s1_vld_r;
  logic             s1_vld_nxt;
  logic             out_vld_r;
  logic             out_vld_nxt;
  srce_pkg::instr_t s1_ins_r;
  srce_pkg::instr_t in_ins;

  assign s1_go    = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = clr_busy || (s1_vld_r && !s1_go);
  assign in_acc   = in_valid && !in_stall;

  assign in_ins.action           = in_action;
  assign in_ins.dest_reg         = in_dest_reg;
  assign in_ins.src_a_reg        = in_src_a_reg;
  assign in_ins.src_b_reg        = in_src_b_reg;
  assign in_ins.load_from_memory = in_load_from_memory;
  assign in_ins.immediate        = in_immediate;
  assign in_ins.address          = in_address;

  always_comb begin
    s1_vld_nxt  = in_acc ? 1'b1 : (s1_go ? 1'b0 : s1_vld_r);
    out_vld_nxt = s1_go ? 1'b1 : (out_stall ? out_vld_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ins_r <= in_ins;
    end
  end

  // operand read addresses at accept time
  logic [RXW-1:0] ra_x;
  logic [RXW-1:0] rb_x;
  logic [AW-1:0]  rd_addr;
  logic           in_addr_ok;
  assign ra_x       = RXW'(in_src_a_reg);
  assign rb_x       = RXW'(in_src_b_reg);
  assign in_addr_ok = !in_address[15] && (CW'(in_address[14:0]) < WORDS_C);
  assign rd_addr    = in_addr_ok ? in_address[AW-1:0] : '0;

  // machine state
  logic [PCW-1:0]       pc_r;
  logic                 halt_r;
  logic                 r0_nz_r;
  logic [WORD_BITS-1:0] opa;
  logic [WORD_BITS-1:0] opb;
  logic [WORD_BITS-1:0] mem_q;
  srce_pkg::wb_ctl_t    ctl;
  logic [PCW-1:0]       pc_nxt;
  logic [RIW-1:0]       reg_idx;
  logic [WORD_BITS-1:0] reg_data;
  logic [AW-1:0]        mem_idx;
  logic [WORD_BITS-1:0] mem_data;
  logic                 rf_we;
  logic                 dm_we;

  assign rf_we = s1_go && ctl.reg_we;
  assign dm_we = s1_go && ctl.mem_we;

  srce_regfile #(
    .REG_COUNT (REG_COUNT),
    .WORD_BITS (WORD_BITS)
  ) u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .re      (in_acc),
    .ra_idx  (ra_x[RIW-1:0]),
    .rb_idx  (rb_x[RIW-1:0]),
    .qa      (opa),
    .qb      (opb),
    .we      (rf_we),
    .wr_idx  (reg_idx),
    .wr_data (reg_data)
  );

  srce_dmem #(
    .MEM_WORDS (MEM_WORDS),
    .WORD_BITS (WORD_BITS)
  ) u_dmem (
    .clk     (clk),
    .rst_n   (rst_n),
    .busy    (clr_busy),
    .re      (in_acc),
    .rd_idx  (rd_addr),
    .q       (mem_q),
    .we      (dm_we),
    .wr_idx  (mem_idx),
    .wr_data (mem_data)
  );

  srce_exec #(
    .MEM_WORDS     (MEM_WORDS),
    .REG_COUNT     (REG_COUNT),
    .PROGRAM_DEPTH (PROGRAM_DEPTH),
    .WORD_BITS     (WORD_BITS)
  ) u_exec (
    .ins      (s1_ins_r),
    .a        (opa),
    .b        (opb),
    .mem_q    (mem_q),
    .pc       (pc_r),
    .halted   (halt_r),
    .r0_nz    (r0_nz_r),
    .prog_len (prog_len_r),
    .ctl      (ctl),
    .pc_nxt   (pc_nxt),
    .reg_idx  (reg_idx),
    .reg_data (reg_data),
    .mem_idx  (mem_idx),
    .mem_data (mem_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      pc_r      <= '0;
      halt_r    <= 1'b0;
      r0_nz_r   <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (s1_go) begin
        pc_r   <= pc_nxt;
        halt_r <= ctl.halt;
      end
      // shadow of r0 so the zero test needs no third read port
      if (rf_we && reg_idx == '0) begin
        r0_nz_r <= |reg_data;
      end
    end
  end

  // output register
  logic [8:0]        out_pc_r;
  logic              out_halt_r;
  srce_pkg::status_t out_status_r;

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_pc_r     <= srce_pkg::PC_OUT_W'(pc_nxt);
      out_halt_r   <= ctl.halt;
      out_status_r <= ctl.status;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_next_pc   = out_pc_r;
  assign out_is_halted = out_halt_r;
  assign out_status    = out_status_r;

  // checks
  a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |=> halt_r)
    else $error("halt flag cleared without reset");

  a_no_write_halted: assert property (@(posedge clk) disable iff (!rst_n)
    halt_r |-> !(rf_we || dm_we))
    else $error("state written while halted");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (in_stall && !clr_busy) |-> (s1_vld_r && out_vld_r && out_stall))
    else $error("input stalled with room in the pipeline");

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r <= PCW'(PROGRAM_DEPTH))
    else $error("program counter beyond program depth");

endmodule

// ===== sv/srce_regfile.sv =====
// register file: one write port, two registered read ports, reset by valid bits
`timescale 1ns / 1ps

module srce_regfile #(
  parameter int REG_COUNT = srce_pkg::REG_COUNT_DEF,
  parameter int WORD_BITS = srce_pkg::WORD_BITS_DEF,
  localparam int RIW      = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 re,
  input  logic [RIW-1:0]       ra_idx,
  input  logic [RIW-1:0]       rb_idx,
  output logic [WORD_BITS-1:0] qa,
  output logic [WORD_BITS-1:0] qb,
  input  logic                 we,
  input  logic [RIW-1:0]       wr_idx,
  input  logic [WORD_BITS-1:0] wr_data
);

  logic [WORD_BITS-1:0] mem [REG_COUNT];
  logic [REG_COUNT-1:0] vld_r;
  logic [WORD_BITS-1:0] qa_r;
  logic [WORD_BITS-1:0] qb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // a write at the same edge is forwarded into the read data
  always_ff @(posedge clk) begin
    if (re) begin
      if (we && wr_idx == ra_idx) begin
        qa_r <= wr_data;
      end else begin
        qa_r <= vld_r[ra_idx] ? mem[ra_idx] : '0;
      end
      if (we && wr_idx == rb_idx) begin
        qb_r <= wr_data;
      end else begin
        qb_r <= vld_r[rb_idx] ? mem[rb_idx] : '0;
      end
    end
  end

  assign qa = qa_r;
  assign qb = qb_r;

endmodule

// ===== sv/srce_dmem.sv =====
// data memory: one write port, one registered read port, clearing pass after reset
`timescale 1ns / 1ps

module srce_dmem #(
  parameter int MEM_WORDS = srce_pkg::MEM_WORDS_DEF,
  parameter int WORD_BITS = srce_pkg::WORD_BITS_DEF,
  localparam int AW       = $clog2(MEM_WORDS)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  output logic                 busy,
  input  logic                 re,
  input  logic [AW-1:0]        rd_idx,
  output logic [WORD_BITS-1:0] q,
  input  logic                 we,
  input  logic [AW-1:0]        wr_idx,
  input  logic [WORD_BITS-1:0] wr_data
);

  localparam logic [AW-1:0] LAST = AW'(MEM_WORDS - 1);

  logic [WORD_BITS-1:0] mem [MEM_WORDS];
  logic [WORD_BITS-1:0] q_r;
  logic [AW-1:0]        clr_cnt_r;
  logic [AW-1:0]        clr_cnt_nxt;
  logic                 busy_r;
  logic                 busy_nxt;

  always_comb begin
    clr_cnt_nxt = clr_cnt_r;
    busy_nxt    = busy_r;
    if (busy_r) begin
      clr_cnt_nxt = clr_cnt_r + AW'(1);
      if (clr_cnt_r == LAST) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
      busy_r    <= 1'b1;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
      busy_r    <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (we) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      q_r <= (we && wr_idx == rd_idx) ? wr_data : mem[rd_idx];
    end
  end

  assign busy = busy_r;
  assign q    = q_r;

endmodule

// ===== sv/srce_exec.sv =====
// execute logic: decodes one instruction against its operands and the machine state
`timescale 1ns / 1ps

module srce_exec #(
  parameter int MEM_WORDS     = srce_pkg::MEM_WORDS_DEF,
  parameter int REG_COUNT     = srce_pkg::REG_COUNT_DEF,
  parameter int PROGRAM_DEPTH = srce_pkg::PROGRAM_DEPTH_DEF,
  parameter int WORD_BITS     = srce_pkg::WORD_BITS_DEF,
  localparam int AW           = $clog2(MEM_WORDS),
  localparam int RIW          = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1,
  localparam int PCW          = $clog2(PROGRAM_DEPTH + 1)
) (
  input  srce_pkg::instr_t           ins,
  input  logic [WORD_BITS-1:0]       a,
  input  logic [WORD_BITS-1:0]       b,
  input  logic [WORD_BITS-1:0]       mem_q,
  input  logic [PCW-1:0]             pc,
  input  logic                       halted,
  input  logic                       r0_nz,
  input  logic [srce_pkg::LEN_W-1:0] prog_len,
  output srce_pkg::wb_ctl_t          ctl,
  output logic [PCW-1:0]             pc_nxt,
  output logic [RIW-1:0]             reg_idx,
  output logic [WORD_BITS-1:0]       reg_data,
  output logic [AW-1:0]              mem_idx,
  output logic [WORD_BITS-1:0]       mem_data
);

  localparam int CW  = srce_pkg::CMP_W;
  localparam int RXW = (RIW > 2) ? RIW : 2;
  localparam logic [CW-1:0]  DEPTH_C = CW'(PROGRAM_DEPTH);
  localparam logic [CW-1:0]  WORDS_C = CW'(MEM_WORDS);
  localparam logic [PCW-1:0] PC_MAX  = PCW'(PROGRAM_DEPTH);
  localparam logic [4:0]     REGS_C  = 5'(REG_COUNT);

  logic [CW-1:0]        len_c;
  logic [CW-1:0]        limit;
  logic [CW-1:0]        addr_mag;
  logic                 addr_ok;
  logic                 br_ok;
  logic                 rd_ok;
  logic                 ra_ok;
  logic                 rb_ok;
  logic [PCW-1:0]       pc_adv;
  logic [RXW-1:0]       rd_x;
  logic [WORD_BITS-1:0] alu_q;

  assign len_c    = CW'(prog_len);
  assign limit    = (len_c < DEPTH_C) ? len_c : DEPTH_C;
  assign addr_mag = CW'(ins.address[14:0]);
  assign addr_ok  = !ins.address[15] && (addr_mag < WORDS_C);
  assign br_ok    = !ins.address[15] && (addr_mag < limit);
  assign rd_ok    = (5'(ins.dest_reg) < REGS_C);
  assign ra_ok    = (5'(ins.src_a_reg) < REGS_C);
  assign rb_ok    = (5'(ins.src_b_reg) < REGS_C);
  assign pc_adv   = (pc >= PC_MAX) ? PC_MAX : pc + PCW'(1);
  assign rd_x     = RXW'(ins.dest_reg);
  assign reg_idx  = rd_x[RIW-1:0];
  assign mem_idx  = addr_ok ? ins.address[AW-1:0] : '0;
  assign mem_data = a;

  always_comb begin
    case (ins.action)
      srce_pkg::ACT_ADD: alu_q = a + b;
      srce_pkg::ACT_SUB: alu_q = a - b;
      srce_pkg::ACT_AND: alu_q = a & b;
      default:           alu_q = a | b;
    endcase
  end

  always_comb begin
    ctl.status = srce_pkg::ST_OK;
    ctl.halt   = halted;
    ctl.reg_we = 1'b0;
    ctl.mem_we = 1'b0;
    pc_nxt     = pc;
    reg_data   = alu_q;
    if (halted) begin
      ctl.status = srce_pkg::ST_HALTED;
    end else begin
      unique case (ins.action) inside
        srce_pkg::ACT_HALT: begin
          ctl.halt = 1'b1;
        end
        srce_pkg::ACT_BRANCH, srce_pkg::ACT_BEZERO: begin
          if (ins.action == srce_pkg::ACT_BEZERO && r0_nz) begin
            pc_nxt = pc_adv;
          end else if (br_ok) begin
            pc_nxt = PCW'(ins.address[14:0]);
          end else begin
            ctl.status = srce_pkg::ST_BAD_BRANCH;
            pc_nxt     = pc_adv;
          end
        end
        srce_pkg::ACT_LOAD: begin
          pc_nxt = pc_adv;
          if (rd_ok) begin
            if (!ins.load_from_memory) begin
              ctl.reg_we = 1'b1;
              reg_data   = WORD_BITS'(ins.immediate);
            end else if (addr_ok) begin
              ctl.reg_we = 1'b1;
              reg_data   = mem_q;
            end else begin
              ctl.status = srce_pkg::ST_BAD_MEM;
            end
          end
        end
        srce_pkg::ACT_STORE: begin
          pc_nxt = pc_adv;
          if (ra_ok) begin
            if (addr_ok) begin
              ctl.mem_we = 1'b1;
            end else begin
              ctl.status = srce_pkg::ST_BAD_MEM;
            end
          end
        end
        srce_pkg::ACT_MOVE: begin
          pc_nxt     = pc_adv;
          ctl.reg_we = rd_ok && ra_ok;
          reg_data   = a;
        end
        srce_pkg::ACT_ADD, srce_pkg::ACT_SUB, srce_pkg::ACT_AND, srce_pkg::ACT_OR: begin
          pc_nxt     = pc_adv;
          ctl.reg_we = rd_ok && ra_ok && rb_ok;
        end
        default: begin
          ctl.status = srce_pkg::ST_BAD_OP;
          pc_nxt     = pc_adv;
        end
      endcase
    end
  end

endmodule
